>>> sv/crsp_pkg.sv
// Shared types and constants for the control-frame resync parser.
// Used by every module of the block; depends on nothing else.
package crsp_pkg;

    localparam int WINDOW_SIZE = 8;
    localparam int FILL_W = $clog2(WINDOW_SIZE);

    localparam logic [7:0] HDR0 = 8'hBB;
    localparam logic [7:0] HDR1 = 8'h66;
    localparam logic [7:0] CMD_SET_INTERVAL = 8'h01;
    localparam logic [7:0] LEN_SET_INTERVAL = 8'h02;
    localparam logic [7:0] CMD_START_UPDATE = 8'h02;

    localparam logic [1:0] KIND_SET_INTERVAL = 2'd0;
    localparam logic [1:0] KIND_START_UPDATE = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t data;
        logic  link_reset;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        byte_t       cmd;
        byte_t       len;
        logic [15:0] interval;
    } result_t;

endpackage

>>> sv/control_frame_resync_parser_top.sv
// Top level of the control-frame resync parser.
// Depends on crsp_pkg, crsp_in_stage, crsp_window and crsp_out_stage.
//
// The parser takes one received byte per item and one item per clock cycle
// while rx_stall is low. The item that completes a valid frame passes the input
// register and then the window check into the result register, from which the
// result leaves. The window is an 8-byte shift line; the header compare,
// six-byte sum and 16-bit checksum compare are done combinationally between
// the input and result registers.
// A full window that fails the check drops its oldest byte; a valid frame
// empties the window and gives one result. An item with link_reset set
// empties the window and its byte is ignored. While a result waits under
// res_stall, one more item is still taken into the input register.
module control_frame_resync_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    input  logic        link_reset,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  frame_kind,
    output logic [7:0]  command_code,
    output logic [7:0]  payload_length,
    output logic [15:0] interval_value
);

    crsp_pkg::rx_item_t rx_item;
    crsp_pkg::rx_item_t item;
    crsp_pkg::result_t  res;
    crsp_pkg::result_t  res_out;
    logic               advance;
    logic               step;
    logic               res_load;

    assign rx_item.data       = rx_byte;
    assign rx_item.link_reset = link_reset;

    crsp_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_stall (rx_stall),
        .rx_item  (rx_item),
        .advance  (advance),
        .step     (step),
        .item     (item)
    );

    crsp_window u_window
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .item     (item),
        .res_load (res_load),
        .res      (res)
    );

    crsp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .advance   (advance),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_out   (res_out)
    );

    assign frame_kind     = res_out.kind;
    assign command_code   = res_out.cmd;
    assign payload_length = res_out.len;
    assign interval_value = res_out.interval;

endmodule

>>> sv/crsp_in_stage.sv
// Input register of the control-frame resync parser.
// Depends on crsp_pkg; hands one registered item per cycle to crsp_window while the pipeline advances.
module crsp_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  crsp_pkg::rx_item_t rx_item,
    input  logic               advance,
    output logic               step,
    output crsp_pkg::rx_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    crsp_pkg::rx_item_t item_reg;
    logic               take;

    // The held item leaves whenever the pipeline advances.
    assign step     = valid_reg && advance;
    assign rx_stall = valid_reg && !advance;
    assign take     = rx_valid && !rx_stall;
    assign item     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (step)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= rx_item;
        end
    end

endmodule

>>> sv/crsp_window.sv
// Byte window, header and checksum check, and frame classification.
// Depends on crsp_pkg; fed by crsp_in_stage, feeds crsp_out_stage.
module crsp_window
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  crsp_pkg::rx_item_t item,
    output logic               res_load,
    output crsp_pkg::result_t  res
);

    // The window is a shift line: the newest byte sits at the top entry and
    // the valid bytes are the top fill_reg entries.
    crsp_pkg::byte_t                win_reg [crsp_pkg::WINDOW_SIZE];
    crsp_pkg::byte_t                cand [crsp_pkg::WINDOW_SIZE];
    logic [crsp_pkg::FILL_W-1:0]    fill_reg;
    logic [crsp_pkg::FILL_W-1:0]    fill_next;
    logic                           full;
    logic                           hdr_ok;
    logic                           sum_ok;
    logic                           frame_ok;
    logic [10:0]                    sum6;

    always_comb
    begin
        for (int i = 0; i < crsp_pkg::WINDOW_SIZE - 1; i++)
        begin
            cand[i] = win_reg[i + 1];
        end
        cand[crsp_pkg::WINDOW_SIZE - 1] = item.data;
    end

    assign full   = (fill_reg == crsp_pkg::FILL_W'(crsp_pkg::WINDOW_SIZE - 1));
    assign hdr_ok = (cand[0] == crsp_pkg::HDR0) && (cand[1] == crsp_pkg::HDR1);
    assign sum6   = {3'b000, cand[0]} + {3'b000, cand[1]} + {3'b000, cand[2]}
                  + {3'b000, cand[3]} + {3'b000, cand[4]} + {3'b000, cand[5]};
    assign sum_ok = ({5'b00000, sum6} == {cand[7], cand[6]});
    assign frame_ok = full && hdr_ok && sum_ok;

    assign res_load = step && !item.link_reset && frame_ok;

    always_comb
    begin
        res.cmd      = cand[2];
        res.len      = cand[3];
        res.interval = 16'h0000;
        if ((cand[2] == crsp_pkg::CMD_SET_INTERVAL) && (cand[3] == crsp_pkg::LEN_SET_INTERVAL))
        begin
            res.kind     = crsp_pkg::KIND_SET_INTERVAL;
            res.interval = {cand[5], cand[4]};
        end
        else if (cand[2] == crsp_pkg::CMD_START_UPDATE)
        begin
            res.kind = crsp_pkg::KIND_START_UPDATE;
        end
        else
        begin
            res.kind = crsp_pkg::KIND_UNKNOWN;
        end
    end

    // A failed check on a full window keeps seven bytes, which drops the oldest.
    always_comb
    begin
        fill_next = fill_reg;
        if (step)
        begin
            if (item.link_reset || frame_ok)
            begin
                fill_next = '0;
            end
            else if (!full)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !item.link_reset)
        begin
            for (int i = 0; i < crsp_pkg::WINDOW_SIZE; i++)
            begin
                win_reg[i] <= cand[i];
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= crsp_pkg::FILL_W'(crsp_pkg::WINDOW_SIZE - 1))
        else $error("window fill out of range");

    a_link_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item.link_reset) |=> (fill_reg == '0))
        else $error("link reset did not empty the window");

    a_frame_empties: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (fill_reg == '0))
        else $error("accepted frame did not empty the window");

    a_frame_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> full)
        else $error("frame reported from a partial window");

    a_interval_only_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> ((res.kind == crsp_pkg::KIND_SET_INTERVAL) || (res.interval == 16'h0000)))
        else $error("interval reported for a non set-interval frame");
`endif

endmodule

>>> sv/crsp_out_stage.sv
// Result register of the control-frame resync parser.
// Depends on crsp_pkg; holds one result until the receiving side takes it.
module crsp_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_load,
    input  crsp_pkg::result_t res,
    output logic              advance,
    output logic              res_valid,
    input  logic              res_stall,
    output crsp_pkg::result_t res_out
);

    logic              valid_reg;
    crsp_pkg::result_t res_reg;

    // The pipeline moves when the result register is empty or being emptied.
    assign advance   = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_out   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

endmodule
